// File: hdl/lcbs_pkg.sv
// Shared types, constants and interleaver size functions for LTE code block segmentation.
package lcbs_pkg;

   // Field widths and sizes fixed by the standard.
   localparam int MAX_CODE_BLOCKS_DEF = 64;
   localparam int B_W                 = 19;
   localparam int K_W                 = 13;
   localparam int IDX_W               = 8;
   localparam int STEP_W              = 3;
   localparam int PC_W                = 4;
   localparam int MAX_BLOCK_BITS      = 6144;
   localparam int BLOCK_CRC_BITS      = 24;
   localparam int SEG_BITS            = MAX_BLOCK_BITS - BLOCK_CRC_BITS;
   localparam int LAST_INDEX          = 188;
   localparam int SEARCH_STEPS        = 8;

   // Division by 6120 = 8 * 765: drop three bits, then multiply by the scaled reciprocal
   // of 765. The quotient is exact for every dividend below 88739 after the shift.
   localparam int SEG_PRESHIFT        = 3;
   localparam int SEG_RECIP           = 87725;
   localparam int SEG_RECIP_SHIFT     = 26;

   // Datapath operations selected by the microcode.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_BP,
      OP_SMUL,
      OP_SCMP,
      OP_KMUL,
      OP_EXCESS,
      OP_SPLIT,
      OP_FINAL,
      OP_OUT
   } op_type;

   // Jump conditions evaluated by the sequencer.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ERR,
      COND_LOOP,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic no_req;
      logic size_err;
      logic loop_nz;
      logic out_busy;
   } status_type;

   // Microcode addresses.
   localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
   localparam logic [PC_W-1:0] PC_ERRCHK = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV    = 4'd2;
   localparam logic [PC_W-1:0] PC_BP     = 4'd3;
   localparam logic [PC_W-1:0] PC_SMUL   = 4'd4;
   localparam logic [PC_W-1:0] PC_SCMP   = 4'd5;
   localparam logic [PC_W-1:0] PC_KMUL   = 4'd6;
   localparam logic [PC_W-1:0] PC_EXCESS = 4'd7;
   localparam logic [PC_W-1:0] PC_SPLIT  = 4'd8;
   localparam logic [PC_W-1:0] PC_FINAL  = 4'd9;
   localparam logic [PC_W-1:0] PC_OUT    = 4'd10;
   localparam logic [PC_W-1:0] PC_RETURN = 4'd11;

   // Turbo interleaver size for a table index; index zero gives zero.
   function automatic logic [K_W-1:0] size_at(input logic [IDX_W-1:0] idx);
      logic [K_W-1:0] k;
      k = K_W'(idx);
      if (idx == '0) begin
         return '0;
      end else if (idx <= IDX_W'(60)) begin
         return K_W'(40) + ((k - K_W'(1)) << 3);
      end else if (idx <= IDX_W'(92)) begin
         return K_W'(512) + ((k - K_W'(60)) << 4);
      end else if (idx <= IDX_W'(124)) begin
         return K_W'(1024) + ((k - K_W'(92)) << 5);
      end else if (idx <= IDX_W'(LAST_INDEX)) begin
         return K_W'(2048) + ((k - K_W'(124)) << 6);
      end else begin
         return K_W'(MAX_BLOCK_BITS);
      end
   endfunction

   // Log2 of the step between a table size and the one just below it.
   function automatic logic [2:0] shift_at(input logic [IDX_W-1:0] idx);
      if (idx <= IDX_W'(60)) begin
         return 3'd3;
      end else if (idx <= IDX_W'(92)) begin
         return 3'd4;
      end else if (idx <= IDX_W'(124)) begin
         return 3'd5;
      end else begin
         return 3'd6;
      end
   endfunction

endpackage

// File: hdl/lcbs_sequencer.sv
// Microcode ROM, step counter and jump logic for the segmentation datapath.
module lcbs_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  lcbs_pkg::status_type     status,
   output lcbs_pkg::ctrl_word_type  ctrl
);

   localparam int PCW = lcbs_pkg::PC_W;

   logic [PCW-1:0] pc_ff;
   logic [PCW-1:0] pc_in;
   logic           take_jump;

   // Control store: one word per step.
   always_comb begin
      case (pc_ff)
         lcbs_pkg::PC_LOAD:   ctrl = '{op: lcbs_pkg::OP_LOAD, cond: lcbs_pkg::COND_NO_REQ,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_ERRCHK: ctrl = '{op: lcbs_pkg::OP_NOP, cond: lcbs_pkg::COND_ERR,
                                       target: lcbs_pkg::PC_OUT};
         lcbs_pkg::PC_DIV:    ctrl = '{op: lcbs_pkg::OP_DIV, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_BP:     ctrl = '{op: lcbs_pkg::OP_BP, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_SMUL:   ctrl = '{op: lcbs_pkg::OP_SMUL, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_SCMP:   ctrl = '{op: lcbs_pkg::OP_SCMP, cond: lcbs_pkg::COND_LOOP,
                                       target: lcbs_pkg::PC_SMUL};
         lcbs_pkg::PC_KMUL:   ctrl = '{op: lcbs_pkg::OP_KMUL, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_EXCESS: ctrl = '{op: lcbs_pkg::OP_EXCESS, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_SPLIT:  ctrl = '{op: lcbs_pkg::OP_SPLIT, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_FINAL:  ctrl = '{op: lcbs_pkg::OP_FINAL, cond: lcbs_pkg::COND_NEVER,
                                       target: lcbs_pkg::PC_LOAD};
         lcbs_pkg::PC_OUT:    ctrl = '{op: lcbs_pkg::OP_OUT, cond: lcbs_pkg::COND_OUT_BUSY,
                                       target: lcbs_pkg::PC_OUT};
         lcbs_pkg::PC_RETURN: ctrl = '{op: lcbs_pkg::OP_NOP, cond: lcbs_pkg::COND_ALWAYS,
                                       target: lcbs_pkg::PC_LOAD};
         default:             ctrl = '{op: lcbs_pkg::OP_NOP, cond: lcbs_pkg::COND_ALWAYS,
                                       target: lcbs_pkg::PC_LOAD};
      endcase
   end

   // Jump condition of the current word.
   always_comb begin
      case (ctrl.cond)
         lcbs_pkg::COND_NEVER:    take_jump = 1'b0;
         lcbs_pkg::COND_ALWAYS:   take_jump = 1'b1;
         lcbs_pkg::COND_NO_REQ:   take_jump = status.no_req;
         lcbs_pkg::COND_ERR:      take_jump = status.size_err;
         lcbs_pkg::COND_LOOP:     take_jump = status.loop_nz;
         lcbs_pkg::COND_OUT_BUSY: take_jump = status.out_busy;
         default:                 take_jump = 1'b1;
      endcase
   end

   assign pc_in = take_jump ? ctrl.target : pc_ff + PCW'(1);

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lcbs_pkg::PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hdl/lte_code_block_segmentation.sv
// LTE turbo code block segmentation: microcoded datapath, output register and checks.
// Only one block is in work at a time: the input stays stalled from an accepted beat until
// its result has been loaded into the output register. The work is an 8-step binary search
// of the interleaver size table and a one-step division by 6120; an oversize block skips both.
// A stalled result beat holds the sequencer in its output step for as long as the stall lasts.
// Reset: synchronous, active high; it returns the step counter to the input wait and clears
// the result valid. No storage needs clearing.
module lte_code_block_segmentation #(
   parameter int MAX_CODE_BLOCKS = lcbs_pkg::MAX_CODE_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [18:0] req_transport_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_block_count,
   output logic [5:0]  rsp_short_count,
   output logic [6:0]  rsp_long_count,
   output logic [12:0] rsp_short_length,
   output logic [12:0] rsp_long_length,
   output logic [5:0]  rsp_filler_bits,
   output logic        rsp_size_error
);

   localparam int BW  = lcbs_pkg::B_W;
   localparam int KW  = lcbs_pkg::K_W;
   localparam int IW  = lcbs_pkg::IDX_W;
   localparam int SW  = lcbs_pkg::STEP_W;
   localparam int CW  = $clog2(MAX_CODE_BLOCKS + 1);
   localparam int PW  = CW + KW;
   localparam int NW  = BW + 1;
   localparam int DW  = NW - lcbs_pkg::SEG_PRESHIFT;
   localparam int MW  = 2 * DW;
   localparam logic [NW-1:0] SIZE_LIMIT = NW'(MAX_CODE_BLOCKS * lcbs_pkg::SEG_BITS);

   lcbs_pkg::ctrl_word_type ctrl;
   lcbs_pkg::status_type    status;

   // Working registers.
   logic [BW-1:0] b_ff, b_in;
   logic          err_ff, err_in;
   logic [CW-1:0] q_ff, q_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] c_ff, c_in;
   logic [PW-1:0] bp_ff, bp_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] mask_ff, mask_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [KW-1:0] kp_ff, kp_in;
   logic [KW-1:0] km_ff, km_in;
   logic [2:0]    sh_ff, sh_in;
   logic [PW-1:0] excess_ff, excess_in;
   logic [CW-1:0] cm_ff, cm_in;

   // Finished plan, held until the output register is free.
   logic [6:0]    r_block_ff, r_block_in;
   logic [5:0]    r_short_cnt_ff, r_short_cnt_in;
   logic [6:0]    r_long_cnt_ff, r_long_cnt_in;
   logic [KW-1:0] r_short_len_ff, r_short_len_in;
   logic [KW-1:0] r_long_len_ff, r_long_len_in;
   logic [5:0]    r_fill_ff, r_fill_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_block_ff, rsp_block_in;
   logic [5:0]    rsp_short_cnt_ff, rsp_short_cnt_in;
   logic [6:0]    rsp_long_cnt_ff, rsp_long_cnt_in;
   logic [KW-1:0] rsp_short_len_ff, rsp_short_len_in;
   logic [KW-1:0] rsp_long_len_ff, rsp_long_len_in;
   logic [5:0]    rsp_fill_ff, rsp_fill_in;
   logic          rsp_err_ff, rsp_err_in;

   // Combinational helpers.
   logic          req_accept;
   logic          out_load;
   logic [NW-1:0] div_num;
   logic [DW-1:0] div_part;
   logic [MW-1:0] div_prod;
   logic [IW-1:0] try_idx;
   logic          try_short;
   logic [IW-1:0] next_idx;
   logic [PW-1:0] cm_raw;
   logic [CW-1:0] cm_sat;
   logic          single_blk;
   logic [PW-1:0] cm_part;
   logic          fill_ok;
   logic [PW-1:0] fill_full;

   lcbs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Handshakes and sequencer status.
   assign req_stall  = (ctrl.op != lcbs_pkg::OP_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = (ctrl.op == lcbs_pkg::OP_OUT) && !(rsp_valid_ff && rsp_stall);

   assign status.no_req   = !req_valid;
   assign status.size_err = err_ff;
   assign status.loop_nz  = (cnt_ff != '0);
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // Ceiling of B/6120: add 6119, drop three bits, then multiply by the reciprocal of 765.
   assign div_num  = NW'(b_ff) + NW'(lcbs_pkg::SEG_BITS - 1);
   assign div_part = div_num[NW-1:lcbs_pkg::SEG_PRESHIFT];
   assign div_prod = MW'(div_part) * MW'(lcbs_pkg::SEG_RECIP);

   // Shared arithmetic for the steps.
   assign try_idx    = pos_ff | mask_ff;
   assign try_short  = (try_idx <= IW'(lcbs_pkg::LAST_INDEX - 1)) && (prod_ff < bp_ff);
   assign next_idx   = pos_ff + IW'(1);
   assign cm_raw     = excess_ff >> sh_ff;
   assign single_blk = (c_ff == CW'(1));
   assign cm_sat     = (cm_raw > PW'(c_ff)) ? c_ff : CW'(cm_raw);
   assign cm_part    = PW'(cm_ff) << sh_ff;
   assign fill_ok    = (excess_ff >= cm_part);
   assign fill_full  = excess_ff - cm_part;

   // Datapath: each microcode operation updates its own registers.
   always_comb begin
      b_in           = b_ff;
      err_in         = err_ff;
      q_in           = q_ff;
      cnt_in         = cnt_ff;
      c_in           = c_ff;
      bp_in          = bp_ff;
      pos_in         = pos_ff;
      mask_in        = mask_ff;
      prod_in        = prod_ff;
      kp_in          = kp_ff;
      km_in          = km_ff;
      sh_in          = sh_ff;
      excess_in      = excess_ff;
      cm_in          = cm_ff;
      r_block_in     = r_block_ff;
      r_short_cnt_in = r_short_cnt_ff;
      r_long_cnt_in  = r_long_cnt_ff;
      r_short_len_in = r_short_len_ff;
      r_long_len_in  = r_long_len_ff;
      r_fill_in      = r_fill_ff;
      case (ctrl.op)
         lcbs_pkg::OP_LOAD: begin
            // Take the block length and flag an oversize block.
            b_in   = req_transport_bits;
            err_in = (NW'(req_transport_bits) > SIZE_LIMIT);
         end
         lcbs_pkg::OP_DIV: begin
            // Block count for a length above one block.
            q_in = CW'(div_prod >> lcbs_pkg::SEG_RECIP_SHIFT);
         end
         lcbs_pkg::OP_BP: begin
            // Block count and the length with all block CRCs added.
            if (b_ff <= BW'(lcbs_pkg::MAX_BLOCK_BITS)) begin
               c_in  = CW'(1);
               bp_in = PW'(b_ff);
            end else begin
               c_in  = q_ff;
               bp_in = PW'(b_ff) + PW'(q_ff) * PW'(lcbs_pkg::BLOCK_CRC_BITS);
            end
            pos_in  = '0;
            mask_in = IW'(1) << (IW - 1);
            cnt_in  = SW'(lcbs_pkg::SEARCH_STEPS - 1);
         end
         lcbs_pkg::OP_SMUL: begin
            prod_in = PW'(lcbs_pkg::size_at(try_idx)) * PW'(c_ff);
         end
         lcbs_pkg::OP_SCMP: begin
            // Keep the trial index while its size is still too small.
            if (try_short) begin
               pos_in = try_idx;
            end
            mask_in = mask_ff >> 1;
            cnt_in  = cnt_ff - SW'(1);
         end
         lcbs_pkg::OP_KMUL: begin
            kp_in   = lcbs_pkg::size_at(next_idx);
            km_in   = lcbs_pkg::size_at(pos_ff);
            sh_in   = lcbs_pkg::shift_at(next_idx);
            prod_in = PW'(lcbs_pkg::size_at(next_idx)) * PW'(c_ff);
         end
         lcbs_pkg::OP_EXCESS: begin
            excess_in = (prod_ff >= bp_ff) ? prod_ff - bp_ff : '0;
         end
         lcbs_pkg::OP_SPLIT: begin
            // The size step is a power of two, so the short count is a shift.
            cm_in = single_blk ? '0 : cm_sat;
         end
         lcbs_pkg::OP_FINAL: begin
            r_block_in     = 7'(c_ff);
            r_short_cnt_in = 6'(cm_ff);
            r_long_cnt_in  = 7'(c_ff - cm_ff);
            r_fill_in      = fill_ok ? 6'(fill_full) : '0;
            if (single_blk) begin
               r_long_len_in  = kp_ff;
               r_short_len_in = '0;
            end else begin
               r_long_len_in  = kp_ff - KW'(lcbs_pkg::BLOCK_CRC_BITS);
               r_short_len_in = (km_ff != '0) ? km_ff - KW'(lcbs_pkg::BLOCK_CRC_BITS) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded when free, kept while the beat is stalled.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_block_in     = rsp_block_ff;
      rsp_short_cnt_in = rsp_short_cnt_ff;
      rsp_long_cnt_in  = rsp_long_cnt_ff;
      rsp_short_len_in = rsp_short_len_ff;
      rsp_long_len_in  = rsp_long_len_ff;
      rsp_fill_in      = rsp_fill_ff;
      rsp_err_in       = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_err_in       = err_ff;
         rsp_block_in     = err_ff ? '0 : r_block_ff;
         rsp_short_cnt_in = err_ff ? '0 : r_short_cnt_ff;
         rsp_long_cnt_in  = err_ff ? '0 : r_long_cnt_ff;
         rsp_short_len_in = err_ff ? '0 : r_short_len_ff;
         rsp_long_len_in  = err_ff ? '0 : r_long_len_ff;
         rsp_fill_in      = err_ff ? '0 : r_fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff             <= b_in;
      err_ff           <= err_in;
      q_ff             <= q_in;
      cnt_ff           <= cnt_in;
      c_ff             <= c_in;
      bp_ff            <= bp_in;
      pos_ff           <= pos_in;
      mask_ff          <= mask_in;
      prod_ff          <= prod_in;
      kp_ff            <= kp_in;
      km_ff            <= km_in;
      sh_ff            <= sh_in;
      excess_ff        <= excess_in;
      cm_ff            <= cm_in;
      r_block_ff       <= r_block_in;
      r_short_cnt_ff   <= r_short_cnt_in;
      r_long_cnt_ff    <= r_long_cnt_in;
      r_short_len_ff   <= r_short_len_in;
      r_long_len_ff    <= r_long_len_in;
      r_fill_ff        <= r_fill_in;
      rsp_block_ff     <= rsp_block_in;
      rsp_short_cnt_ff <= rsp_short_cnt_in;
      rsp_long_cnt_ff  <= rsp_long_cnt_in;
      rsp_short_len_ff <= rsp_short_len_in;
      rsp_long_len_ff  <= rsp_long_len_in;
      rsp_fill_ff      <= rsp_fill_in;
      rsp_err_ff       <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_count  = rsp_block_ff;
   assign rsp_short_count  = rsp_short_cnt_ff;
   assign rsp_long_count   = rsp_long_cnt_ff;
   assign rsp_short_length = rsp_short_len_ff;
   assign rsp_long_length  = rsp_long_len_ff;
   assign rsp_filler_bits  = rsp_fill_ff;
   assign rsp_size_error   = rsp_err_ff;

`ifndef ASSERT_OFF
   // Only one block is in work at a time: an accepted beat closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a block was in work");

   // An oversize block carries no plan.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> rsp_block_count == '0 && rsp_long_count == '0 &&
         rsp_short_count == '0 && rsp_long_length == '0 && rsp_short_length == '0 &&
         rsp_filler_bits == '0)
      else $error("oversize result with non-zero fields");

   // Long and short blocks make up the whole count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_size_error |-> rsp_block_count == 7'(rsp_short_count) + rsp_long_count)
      else $error("block counts do not add up");

   // A single block has no short part.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_size_error && rsp_block_count == 7'd1 |->
         rsp_short_count == '0 && rsp_short_length == '0)
      else $error("single block reports a short block");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LTE code block segmentation block.
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_BLOCKS     = lcbs_pkg::MAX_CODE_BLOCKS_DEF;
   localparam int MAX_TB_BITS    = MAX_BLOCKS * lcbs_pkg::SEG_BITS;
   localparam int RANDOM_ITEMS   = 1330;
   localparam int IDLE_PERCENT   = 10;
   localparam int QUIET_FIRST    = 700;
   localparam int QUIET_LAST     = 900;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;

   // One segmentation plan, at the widths of the result ports.
   typedef struct packed {
      logic [6:0]  block_count;
      logic [5:0]  short_count;
      logic [6:0]  long_count;
      logic [12:0] short_length;
      logic [12:0] long_length;
      logic [5:0]  filler_bits;
      logic        size_error;
   } seg_plan_type;

   // A transport block waiting to be sent; drain_first holds it back until all plans are in.
   typedef struct {
      logic [18:0] bits;
      bit          drain_first;
   } transport_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [18:0] req_transport_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_block_count;
   logic [5:0]  rsp_short_count;
   logic [6:0]  rsp_long_count;
   logic [12:0] rsp_short_length;
   logic [12:0] rsp_long_length;
   logic [5:0]  rsp_filler_bits;
   logic        rsp_size_error;

   transport_item_type transport_queue[$];
   seg_plan_type       plan_queue[$];
   int                 sent_count = 0;
   int                 plan_count = 0;
   int                 mismatch_count = 0;
   int                 failure_count = 0;
   int                 quiet_cycles = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   bit                 req_fire;
   bit                 rsp_fire;
   bit                 hold_back;
   seg_plan_type       got_plan;
   seg_plan_type       want_plan;

   lte_code_block_segmentation u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_transport_bits (req_transport_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_block_count    (rsp_block_count),
      .rsp_short_count    (rsp_short_count),
      .rsp_long_count     (rsp_long_count),
      .rsp_short_length   (rsp_short_length),
      .rsp_long_length    (rsp_long_length),
      .rsp_filler_bits    (rsp_filler_bits),
      .rsp_size_error     (rsp_size_error)
   );

   always #5 clock = ~clock;

   // Turbo interleaver size by table index, built from the four step regions.
   function automatic int turbo_size(input int index);
      if (index <= 0) begin
         return 0;
      end else if (index <= 60) begin
         return 40 + 8 * (index - 1);
      end else if (index <= 92) begin
         return 512 + 16 * (index - 60);
      end else if (index <= 124) begin
         return 1024 + 32 * (index - 92);
      end
      return 2048 + 64 * (index - 124);
   endfunction

   // Works out the segmentation plan for a transport block of the given length.
   function automatic seg_plan_type plan_segmentation(input logic [18:0] transport_bits);
      seg_plan_type plan;
      int b, blocks, padded, pick, k_long, k_short, n_short, n_long, excess, filler, total;
      plan = '0;
      b = int'(transport_bits);
      if (b > MAX_TB_BITS) begin
         plan.size_error = 1'b1;
         return plan;
      end
      if (b <= lcbs_pkg::MAX_BLOCK_BITS) begin
         blocks = 1;
         padded = b;
      end else begin
         blocks = (b + lcbs_pkg::SEG_BITS - 1) / lcbs_pkg::SEG_BITS;
         padded = b + blocks * lcbs_pkg::BLOCK_CRC_BITS;
      end
      // Walk down the table so that the last hit is the smallest size that fits.
      pick = lcbs_pkg::LAST_INDEX;
      for (int i = lcbs_pkg::LAST_INDEX; i >= 1; i--) begin
         if (blocks * turbo_size(i) >= padded) begin
            pick = i;
         end
      end
      k_long = turbo_size(pick);
      if (blocks == 1) begin
         k_short = 0;
         n_short = 0;
         n_long = 1;
         filler = (k_long >= b) ? k_long - b : 0;
      end else begin
         k_short = turbo_size(pick - 1);
         excess = (blocks * k_long >= padded) ? blocks * k_long - padded : 0;
         n_short = (k_long != k_short) ? excess / (k_long - k_short) : 0;
         if (n_short > blocks) begin
            n_short = blocks;
         end
         n_long = blocks - n_short;
         total = n_long * k_long + n_short * k_short;
         filler = (total >= padded) ? total - padded : 0;
         k_long -= lcbs_pkg::BLOCK_CRC_BITS;
         if (k_short > 0) begin
            k_short -= lcbs_pkg::BLOCK_CRC_BITS;
         end
      end
      plan.block_count  = 7'(blocks);
      plan.short_count  = 6'(n_short);
      plan.long_count   = 7'(n_long);
      plan.short_length = 13'(k_short);
      plan.long_length  = 13'(k_long);
      plan.filler_bits  = 6'(filler);
      return plan;
   endfunction

   // Sender: offers queued beats, idles at random and pauses for a full drain where marked.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            plan_queue.push_back(plan_segmentation(req_transport_bits));
            sent_count++;
         end
         if (!req_valid || req_fire) begin
            hold_back = transport_queue.size() == 0;
            if (!hold_back && transport_queue[0].drain_first && plan_queue.size() != 0) begin
               hold_back = 1'b1;
            end
            if (!(sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) &&
                $urandom_range(99) < IDLE_PERCENT) begin
               hold_back = 1'b1;
            end
            if (hold_back) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_transport_bits <= transport_queue[0].bits;
               void'(transport_queue.pop_front());
            end
         end
      end
   end

   // Receiver stall: random idling, one long hold-off, and a quiet stretch without stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && plan_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (plan_count >= QUIET_FIRST && plan_count < QUIET_LAST) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= $urandom_range(99) < IDLE_PERCENT;
         end
      end
   end

   // Checker: compares each result beat with the oldest predicted plan.
   always @(posedge clock) begin
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (rsp_fire) begin
         got_plan = '{rsp_block_count, rsp_short_count, rsp_long_count, rsp_short_length,
                      rsp_long_length, rsp_filler_bits, rsp_size_error};
         if (plan_queue.size() == 0) begin
            failure_count++;
            $display("Unexpected result beat: %p", got_plan);
         end else begin
            want_plan = plan_queue.pop_front();
            plan_count++;
            if (got_plan.block_count !== want_plan.block_count ||
                got_plan.short_count !== want_plan.short_count ||
                got_plan.long_count !== want_plan.long_count ||
                got_plan.short_length !== want_plan.short_length ||
                got_plan.long_length !== want_plan.long_length ||
                got_plan.filler_bits !== want_plan.filler_bits ||
                got_plan.size_error !== want_plan.size_error) begin
               failure_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch on result %0d: expected %p, got %p",
                           plan_count, want_plan, got_plan);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Stimulus: directed corner lengths first, then a random mix weighted towards valid sizes.
   initial begin
      logic [18:0]        directed[$];
      transport_item_type item;
      int                 pick, blocks;
      directed = '{19'd0, 19'd1, 19'd39, 19'd40, 19'd41, 19'd511, 19'd512, 19'd1024,
                   19'd2048, 19'd3000, 19'd6143, 19'd6144, 19'd6145, 19'd6224, 19'd12240,
                   19'd12241, 19'd100000, 19'd262144, 19'd391679, 19'd391680, 19'd391681,
                   19'd524287};
      foreach (directed[i]) begin
         item.bits = directed[i];
         item.drain_first = 1'b0;
         transport_queue.push_back(item);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            item.bits = 19'($urandom_range(lcbs_pkg::MAX_BLOCK_BITS));
         end else if (pick < 75) begin
            item.bits = 19'($urandom_range(MAX_TB_BITS, lcbs_pkg::MAX_BLOCK_BITS + 1));
         end else if (pick < 88) begin
            // Lengths next to a whole number of segments, where the block count steps.
            blocks = $urandom_range(MAX_BLOCKS, 1);
            item.bits = 19'(blocks * lcbs_pkg::SEG_BITS - 1 + $urandom_range(2));
         end else begin
            item.bits = 19'($urandom_range(524287, MAX_TB_BITS + 1));
         end
         // Two points in the run where the sender waits for every plan to arrive.
         item.drain_first = (n == 400) || (n == 1000);
         transport_queue.push_back(item);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (transport_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (plan_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failure_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
